>>> hw/rtl/double_ended_priority_queue_core_defines.svh
// Assertion helpers shared by the queue RTL.
// Every use samples on the rising edge of clk and is held off while rst is high.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`define DEPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define DEPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define DEPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/depq_pkg.sv
`default_nettype none
package depq_pkg;

  localparam int ID_W  = 20;
  localparam int PRI_W = 24;

  localparam int DEFAULT_CAPACITY = 256;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_POP_HIGH = 2'd1;
  localparam logic [1:0] KIND_POP_LOW  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } depq_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_REMOVE
  } depq_cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    depq_cell_op_t    op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [PRI_W-1:0] top_pri;
  } depq_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_HIGH
  } depq_state_t;

  // Stands left of cell 0: occupied, lowest priority, so the chain stays a sorted prefix.
  localparam depq_entry_t ENTRY_LEFT_EDGE = '{valid: 1'b1, id: '0, pri: '0};
  localparam depq_entry_t ENTRY_EMPTY     = '{valid: 1'b0, id: '0, pri: '0};

endpackage
`default_nettype wire

>>> hw/rtl/depq_cell.sv
`default_nettype none
`include "double_ended_priority_queue_core_defines.svh"
module depq_cell
  import depq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire depq_ctrl_t       ctrl,
  input  wire depq_entry_t      left_entry,
  input  wire depq_entry_t      right_entry,
  input  wire logic             left_after,
  input  wire logic             left_match,
  output depq_entry_t           entry,
  output logic                  after,
  output logic                  match,
  output logic [PRI_W-1:0]      last_pri,
  output logic [ID_W-1:0]       first_id
);

  depq_entry_t entry_next;
  logic        first;

  // Cells are kept sorted by priority, oldest first among equal priorities.
  // A new pair lands after every entry with a priority not above its own.
  assign after    = entry.valid && (entry.pri <= ctrl.pri);
  assign match    = entry.valid && (entry.pri == ctrl.top_pri);
  assign first    = match && !left_match;
  assign last_pri = (entry.valid && !right_entry.valid) ? entry.pri : '0;
  assign first_id = first ? entry.id : '0;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!after) begin
          if (left_after) begin
            entry_next = '{valid: 1'b1, id: ctrl.id, pri: ctrl.pri};
          end else begin
            entry_next = left_entry;
          end
        end
      end
      CELL_SHIFT: begin
        entry_next = right_entry;
      end
      CELL_REMOVE: begin
        // The top group runs to the end of the chain, so every matching cell closes the gap.
        if (match) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Only the valid bit needs a reset; the payload of a free cell is never looked at.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.id  <= entry_next.id;
    entry.pri <= entry_next.pri;
  end

  `DEPQ_ASSERT_IMPL(a_cell_prefix, entry.valid, left_entry.valid,
                    "occupied cell after a free one")
  `DEPQ_ASSERT_IMPL(a_cell_sorted, entry.valid, left_entry.pri <= entry.pri,
                    "chain out of order")

endmodule
`default_nettype wire

>>> hw/rtl/double_ended_priority_queue_core.sv
// Double-ended priority queue of up to CAPACITY (identifier, priority) pairs, held in a
// chain of cells sorted by priority with the oldest pair first among equal priorities.
// Every request beat returns exactly one response beat. An insert or a pop of the lowest
// priority shifts the whole chain as the request is taken. A pop of the highest priority
// first registers the priority of the last occupied cell, then locates the oldest cell of
// that priority and closes the gap behind it. A new request is taken while a response
// still waits, as long as the response register is freed in the same cycle. Reset empties
// the queue at once, with no clearing pass.
`default_nettype none
`include "double_ended_priority_queue_core_defines.svh"
module double_ended_priority_queue_core
  import depq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [ID_W-1:0]  client_id,
  input  wire logic [PRI_W-1:0] priority_req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output logic [1:0]            status,
  output logic [ID_W-1:0]       popped_id
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  depq_state_t       state, state_next;
  logic [OCC_W-1:0]  occupancy, occupancy_next;
  logic [PRI_W-1:0]  top_pri, top_pri_next;
  logic              rsp_valid_next;
  logic [1:0]        status_next;
  logic [ID_W-1:0]   popped_id_next;

  depq_ctrl_t        ctrl;
  depq_entry_t       cell_entry    [CAPACITY];
  logic [CAPACITY-1:0] cell_after;
  logic [CAPACITY-1:0] cell_match;
  logic [PRI_W-1:0]  cell_last_pri [CAPACITY];
  logic [ID_W-1:0]   cell_first_id [CAPACITY];
  logic [PRI_W-1:0]  last_pri_any;
  logic [ID_W-1:0]   first_id_any;
  logic              accept;
  logic              full;
  logic              empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    depq_entry_t left_e, right_e;
    logic        left_a, left_m;

    if (i == 0) begin : g_left_edge
      assign left_e = ENTRY_LEFT_EDGE;
      assign left_a = 1'b1;
      assign left_m = 1'b0;
    end else begin : g_left
      assign left_e = cell_entry[i-1];
      assign left_a = cell_after[i-1];
      assign left_m = cell_match[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign right_e = ENTRY_EMPTY;
    end else begin : g_right
      assign right_e = cell_entry[i+1];
    end

    depq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_after  (left_a),
      .left_match  (left_m),
      .entry       (cell_entry[i]),
      .after       (cell_after[i]),
      .match       (cell_match[i]),
      .last_pri    (cell_last_pri[i]),
      .first_id    (cell_first_id[i])
    );
  end

  // At most one cell flags itself as last or as first of the top group, so an OR picks it.
  always_comb begin
    last_pri_any = '0;
    first_id_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      last_pri_any = last_pri_any | cell_last_pri[i];
      first_id_any = first_id_any | cell_first_id[i];
    end
  end

  assign full      = (occupancy == OCC_W'(CAPACITY));
  assign empty     = (occupancy == '0);
  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top_pri   <= top_pri_next;
    status    <= status_next;
    popped_id <= popped_id_next;
  end

  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    top_pri_next   = top_pri;
    rsp_valid_next = rsp_valid && !rsp_ready;
    status_next    = status;
    popped_id_next = popped_id;
    ctrl.op        = CELL_HOLD;
    ctrl.id        = client_id;
    ctrl.pri       = priority_req;
    ctrl.top_pri   = top_pri;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          rsp_valid_next = 1'b1;
          status_next    = STATUS_OK;
          popped_id_next = '0;
          case (kind)
            KIND_INSERT: begin
              if (full) begin
                status_next = STATUS_FULL;
              end else begin
                ctrl.op        = CELL_INSERT;
                occupancy_next = occupancy + OCC_W'(1);
              end
            end
            KIND_POP_HIGH: begin
              if (empty) begin
                status_next = STATUS_EMPTY;
              end else begin
                rsp_valid_next = 1'b0;
                top_pri_next   = last_pri_any;
                state_next     = ST_POP_HIGH;
              end
            end
            KIND_POP_LOW: begin
              if (empty) begin
                status_next = STATUS_EMPTY;
              end else begin
                popped_id_next = cell_entry[0].id;
                ctrl.op        = CELL_SHIFT;
                occupancy_next = occupancy - OCC_W'(1);
              end
            end
            default: begin
              status_next = STATUS_OK;
            end
          endcase
        end
      end
      ST_POP_HIGH: begin
        // The response register was freed when this request was taken.
        ctrl.op        = CELL_REMOVE;
        popped_id_next = first_id_any;
        status_next    = STATUS_OK;
        rsp_valid_next = 1'b1;
        occupancy_next = occupancy - OCC_W'(1);
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `DEPQ_ASSERT(a_occ_bound, occupancy <= OCC_W'(CAPACITY), "occupancy above capacity")
  `DEPQ_ASSERT(a_occ_cells, cell_entry[0].valid == (occupancy != '0), "occupancy disagrees with chain")
  `DEPQ_ASSERT_NEXT(a_pop_high_done, state == ST_POP_HIGH, state == ST_IDLE && rsp_valid, "pop-highest did not finish")
  `DEPQ_ASSERT_IMPL(a_pop_high_nonempty, state == ST_POP_HIGH, !empty && !rsp_valid, "pop-highest on empty or busy output")

endmodule
`default_nettype wire

>>> verif/depq_response_checker.sv
`timescale 1ns / 1ps
module depq_response_checker
  import depq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  logic [1:0]       kind,
  input  logic [ID_W-1:0]  client_id,
  input  logic [PRI_W-1:0] priority_req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  logic [1:0]       status,
  input  logic [ID_W-1:0]  popped_id,
  output int               mismatches,
  output int               pending,
  output int               responses_checked,
  output int               full_drops,
  output int               empty_pops
);

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] id;
  } answer_t;

  // Held pairs in arrival order, so the lowest index wins a priority tie.
  logic [ID_W-1:0]  held_id  [CAPACITY];
  logic [PRI_W-1:0] held_pri [CAPACITY];
  int               held_count;
  answer_t          awaited_answers[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic apply_command(input logic [1:0] k, input logic [ID_W-1:0] cid,
                               input logic [PRI_W-1:0] pri, output answer_t ans);
    int pick;
    ans.status = STATUS_OK;
    ans.id     = '0;
    case (k)
      KIND_INSERT: begin
        if (held_count >= CAPACITY) begin
          ans.status = STATUS_FULL;
        end else begin
          held_id[held_count]  = cid;
          held_pri[held_count] = pri;
          held_count++;
        end
      end
      KIND_POP_HIGH, KIND_POP_LOW: begin
        if (held_count == 0) begin
          ans.status = STATUS_EMPTY;
        end else begin
          pick = 0;
          for (int i = 1; i < held_count; i++) begin
            if (k == KIND_POP_HIGH ? held_pri[i] > held_pri[pick]
                                   : held_pri[i] < held_pri[pick]) begin
              pick = i;
            end
          end
          ans.id = held_id[pick];
          for (int i = pick; i < held_count - 1; i++) begin
            held_id[i]  = held_id[i+1];
            held_pri[i] = held_pri[i+1];
          end
          held_count--;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      held_count = 0;
      awaited_answers.delete();
      mismatches        = 0;
      pending           = 0;
      responses_checked = 0;
      full_drops        = 0;
      empty_pops        = 0;
    end else begin
      // A response beat always belongs to an earlier request, so it is matched first.
      if (rsp_valid && rsp_ready) begin
        responses_checked++;
        if (awaited_answers.size() == 0) begin
          report_mismatch("unrequested response", 32'd0, 32'({status, popped_id}));
        end else begin
          want = awaited_answers.pop_front();
          if (status !== want.status) begin
            report_mismatch("status", 32'(want.status), 32'(status));
          end
          if (popped_id !== want.id) begin
            report_mismatch("popped_id", 32'(want.id), 32'(popped_id));
          end
        end
      end
      if (req_valid && req_ready) begin
        apply_command(kind, client_id, priority_req, want);
        if (want.status == STATUS_FULL) begin
          full_drops++;
        end
        if (want.status == STATUS_EMPTY) begin
          empty_pops++;
        end
        awaited_answers.push_back(want);
      end
      pending = awaited_answers.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import depq_pkg::*;

  localparam int         CAPACITY         = DEFAULT_CAPACITY;
  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam int         COMMAND_TARGET   = 1100;
  localparam int         QUIET_TAIL       = 150;
  localparam int         LONG_HOLD_CYCLES = 300;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         CYCLE_LIMIT      = 200000;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  logic [1:0]       kind;
  logic [ID_W-1:0]  client_id;
  logic [PRI_W-1:0] priority_req;
  logic             rsp_valid;
  logic             rsp_ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  popped_id;

  int mismatches;
  int pending;
  int responses_checked;
  int full_drops;
  int empty_pops;

  int commands_sent;
  int stock;
  int phases_run;
  bit no_idle;
  bit hold_request;

  double_ended_priority_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .client_id    (client_id),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .popped_id    (popped_id)
  );

  depq_response_checker #(.CAPACITY(CAPACITY)) rsp_check (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .kind              (kind),
    .client_id         (client_id),
    .priority_req      (priority_req),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .status            (status),
    .popped_id         (popped_id),
    .mismatches        (mismatches),
    .pending           (pending),
    .responses_checked (responses_checked),
    .full_drops        (full_drops),
    .empty_pops        (empty_pops)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d responses outstanding", cycles, pending);
    $display("simulation failed");
    $finish;
  end

  // Response side: short random stalls, plus one long hold-off on request.
  initial begin : receiver
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Offers one request beat and returns at the edge where it is accepted.
  task automatic offer(input logic [1:0] k, input logic [ID_W-1:0] cid,
                       input logic [PRI_W-1:0] pri);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid    <= 1'b1;
    kind         <= k;
    client_id    <= cid;
    priority_req <= pri;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (k == KIND_INSERT) begin
      if (stock < CAPACITY) begin
        stock++;
      end
    end else if (k != KIND_UNUSED) begin
      if (stock > 0) begin
        stock--;
      end
    end
    if (k != KIND_UNUSED) begin
      commands_sent++;
    end
    if (commands_sent >= COMMAND_TARGET - QUIET_TAIL) begin
      no_idle = 1'b1;
    end
  endtask

  task automatic offer_random(input int insert_pct);
    logic [1:0]       k;
    logic [ID_W-1:0]  cid;
    logic [PRI_W-1:0] pri;
    if ($urandom_range(0, 99) < 3) begin
      k = KIND_UNUSED;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      k = KIND_INSERT;
    end else begin
      k = $urandom_range(0, 1) ? KIND_POP_HIGH : KIND_POP_LOW;
    end
    // Narrow priority bands make ties common, so the oldest-first rule gets exercised.
    case ($urandom_range(0, 3))
      0: pri = PRI_W'($urandom_range(0, 7));
      1: pri = $urandom_range(0, 1) ? {PRI_W{1'b1}} : {PRI_W{1'b0}};
      2: pri = {PRI_W{1'b1}} - PRI_W'($urandom_range(0, 7));
      default: pri = PRI_W'($urandom());
    endcase
    cid = ($urandom_range(0, 15) == 0) ? {ID_W{1'b1}} : ID_W'($urandom());
    offer(k, cid, pri);
  endtask

  task automatic wait_all_answered();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    kind         <= KIND_INSERT;
    client_id    <= '0;
    priority_req <= '0;
    stock         = 0;
    commands_sent = 0;
    phases_run    = 0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty pops, the unused kind, field extremes and a three-way priority tie.
    offer(KIND_POP_HIGH, '1, '1);
    offer(KIND_POP_LOW, '1, '1);
    offer(KIND_UNUSED, '1, '1);
    offer(KIND_INSERT, {ID_W{1'b1}}, {PRI_W{1'b1}});
    offer(KIND_INSERT, '0, '0);
    offer(KIND_INSERT, ID_W'(11), PRI_W'(7));
    offer(KIND_INSERT, ID_W'(12), PRI_W'(7));
    offer(KIND_INSERT, ID_W'(13), PRI_W'(7));
    offer(KIND_INSERT, ID_W'(14), {PRI_W{1'b1}});
    offer(KIND_POP_HIGH, '0, '0);
    offer(KIND_POP_HIGH, '1, '1);
    offer(KIND_POP_LOW, '0, '0);
    offer(KIND_POP_HIGH, '0, '0);
    offer(KIND_POP_LOW, '0, '0);
    offer(KIND_UNUSED, '0, '0);
    offer(KIND_POP_LOW, '0, '0);
    offer(KIND_POP_LOW, '0, '0);
    offer(KIND_POP_HIGH, '0, '0);
    wait_all_answered();

    // Alternate filling to overflow, mixed traffic, and draining past empty.
    while (commands_sent < COMMAND_TARGET) begin
      case (phases_run % 4)
        0: begin
          while (stock < CAPACITY) offer_random(90);
          repeat (12) offer_random(97);
        end
        1: begin
          if (phases_run == 1) begin
            hold_request = 1'b1;
          end
          repeat (120) offer_random(50);
        end
        2: begin
          wait_all_answered();
          while (stock > 0) offer_random(8);
          repeat (6) offer_random(3);
        end
        default: begin
          repeat (120) offer_random(55);
        end
      endcase
      phases_run++;
    end

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d queue commands with %0d responses checked over %0d random phases,",
             commands_sent, responses_checked, phases_run);
    $display("including %0d inserts dropped on a full queue and %0d pops of an empty queue.",
             full_drops, empty_pops);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
